@@ rtl/dmf_pkg.sv @@
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared types and constants for the diploid multiplicative fitness block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmf_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [15:0] HOM_SCALE_RESET = 16'd16384;  // 1.0 in Q2.14

    localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [1:0] MODE_EVALUATE    = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [31:0]        variant_key;
        logic signed [15:0] selection;
        logic signed [15:0] dominance;
        logic [31:0]        start_fitness;
        logic               same_gamete;
    } dmf_in_t;

    typedef struct packed {
        logic [31:0] fitness;
        logic        saturated;
        logic        list_overflow;
    } dmf_out_t;

    // one stored list entry
    typedef struct packed {
        logic [31:0]        key;
        logic signed [15:0] sel;
        logic signed [15:0] dom;
    } dmf_entry_t;

    localparam int ENTRY_W = $bits(dmf_entry_t);

    // request to the product unit
    typedef struct packed {
        logic               go;
        logic               hom;      // 1: 1 + s*hom_scale, 0: 1 + h*s
        logic signed [15:0] sel;
        logic signed [15:0] dom;
        logic [31:0]        fitness;
    } dmf_step_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] fitness;
        logic        sat;
    } dmf_step_rsp_t;

endpackage

`default_nettype wire

@@ rtl/diploid_multiplicative_fitness.sv @@
// ----------------------------------------------------------------------------
// diploid_multiplicative_fitness
// Two variant lists in RAM, merged by key to scale a Q8.24 fitness.
//
//   channel   ports              payload     direction
//   input     s_valid/s_ready    dmf_in_t    in
//   result    m_valid/m_ready    dmf_out_t   out
//   config    cfg_we/cfg_wdata   hom_scale   in
//
// Loads are taken back to back while idle. Each merge step of an evaluate
// reads both RAMs, compares keys and waits on the four-stage product unit;
// a same-gamete evaluate skips the merge and finishes directly.
// Reset is synchronous; lists need no clearing, only the counts are reset.
// A result waiting on m_ready does not block loads; a finished evaluate
// holds until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module diploid_multiplicative_fitness
    import dmf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire dmf_in_t     s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output dmf_out_t         m_data
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_CMP  = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [15:0]   hom_scale_reg;
    logic [CNT_W-1:0] first_cnt_reg, second_cnt_reg;
    logic [CNT_W-1:0] i_reg, j_reg;
    logic          ovf_reg;
    logic [31:0]   f_reg;
    logic          sat_reg;
    logic          adv_i_reg, adv_j_reg;
    logic          m_valid_reg;
    dmf_out_t      m_data_reg;

    logic          accept;
    logic          first_full, second_full;
    logic          we_first, we_second;
    logic          out_free;
    logic          a_ok, b_ok;
    dmf_entry_t    wentry, ent_a, ent_b;
    logic [ENTRY_W-1:0] rd_a, rd_b;
    dmf_step_req_t req;
    dmf_step_rsp_t rsp;
    logic          adv_i, adv_j;

    assign accept      = s_valid && s_ready;
    assign s_ready     = (state_reg == ST_IDLE);
    assign first_full  = (first_cnt_reg == CNT_W'(LIST_DEPTH));
    assign second_full = (second_cnt_reg == CNT_W'(LIST_DEPTH));
    assign we_first    = accept && (s_data.mode == MODE_LOAD_FIRST) && !first_full;
    assign we_second   = accept && (s_data.mode == MODE_LOAD_SECOND) && !second_full;
    assign out_free    = !m_valid_reg || m_ready;
    assign wentry      = '{key: s_data.variant_key, sel: s_data.selection,
                           dom: s_data.dominance};

    dmf_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ENTRY_W)) u_first_ram (
        .aclk  (aclk),
        .we    (we_first),
        .waddr (first_cnt_reg[IDX_W-1:0]),
        .wdata (wentry),
        .raddr (i_reg[IDX_W-1:0]),
        .rdata (rd_a)
    );

    dmf_list_ram #(.DEPTH(LIST_DEPTH), .WIDTH(ENTRY_W)) u_second_ram (
        .aclk  (aclk),
        .we    (we_second),
        .waddr (second_cnt_reg[IDX_W-1:0]),
        .wdata (wentry),
        .raddr (j_reg[IDX_W-1:0]),
        .rdata (rd_b)
    );

    dmf_fit_unit u_fit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hom_scale (hom_scale_reg),
        .req       (req),
        .rsp       (rsp)
    );

    assign ent_a = rd_a;
    assign ent_b = rd_b;
    assign a_ok  = (i_reg < first_cnt_reg);
    assign b_ok  = (j_reg < second_cnt_reg);

    // merge decision
    always_comb begin
        req         = '{go: 1'b0, hom: 1'b0, sel: ent_a.sel, dom: ent_a.dom,
                        fitness: f_reg};
        adv_i       = 1'b0;
        adv_j       = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_data.mode == MODE_EVALUATE) begin
                    state_next = s_data.same_gamete ? ST_DONE : ST_RD;
                end
            end
            ST_RD: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_WAIT;
                req.go     = 1'b1;
                if (a_ok && b_ok) begin
                    if (ent_a.key == ent_b.key) begin
                        req.hom = 1'b1;
                        adv_i   = 1'b1;
                        adv_j   = 1'b1;
                    end else if (ent_a.key < ent_b.key) begin
                        adv_i   = 1'b1;
                    end else begin
                        req.sel = ent_b.sel;
                        req.dom = ent_b.dom;
                        adv_j   = 1'b1;
                    end
                end else if (a_ok) begin
                    adv_i = 1'b1;
                end else if (b_ok) begin
                    req.sel = ent_b.sel;
                    req.dom = ent_b.dom;
                    adv_j   = 1'b1;
                end else begin
                    req.go     = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_WAIT: begin
                if (rsp.done) begin
                    state_next = ST_RD;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            hom_scale_reg  <= HOM_SCALE_RESET;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                hom_scale_reg <= cfg_wdata;
            end
            if (we_first) begin
                first_cnt_reg <= first_cnt_reg + CNT_W'(1);
            end
            if (we_second) begin
                second_cnt_reg <= second_cnt_reg + CNT_W'(1);
            end
            if (accept && ((s_data.mode == MODE_LOAD_FIRST && first_full) ||
                           (s_data.mode == MODE_LOAD_SECOND && second_full))) begin
                ovf_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DONE && out_free) begin
                first_cnt_reg  <= '0;
                second_cnt_reg <= '0;
                ovf_reg        <= 1'b0;
            end
        end
    end

    // merge datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept && s_data.mode == MODE_EVALUATE) begin
            f_reg   <= s_data.start_fitness;
            sat_reg <= 1'b0;
            i_reg   <= '0;
            j_reg   <= '0;
        end
        if (state_reg == ST_CMP) begin
            adv_i_reg <= adv_i;
            adv_j_reg <= adv_j;
        end
        if (state_reg == ST_WAIT && rsp.done) begin
            f_reg   <= rsp.fitness;
            sat_reg <= sat_reg | rsp.sat;
            i_reg   <= i_reg + CNT_W'(adv_i_reg);
            j_reg   <= j_reg + CNT_W'(adv_j_reg);
        end
        if (state_reg == ST_DONE && out_free) begin
            m_data_reg <= '{fitness: f_reg, saturated: sat_reg, list_overflow: ovf_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // merge indices never pass the fill counts while an evaluate runs
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (i_reg <= first_cnt_reg) && (j_reg <= second_cnt_reg))
        else $error("merge index beyond list count");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (first_cnt_reg <= CNT_W'(LIST_DEPTH)) && (second_cnt_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list count beyond depth");

    a_rsp_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> (state_reg == ST_WAIT))
        else $error("product result outside wait state");

    a_same_gamete: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.mode == MODE_EVALUATE && s_data.same_gamete) |=>
        (state_reg == ST_DONE) && !sat_reg)
        else $error("same-gamete evaluate did not bypass merge");

    a_done_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=>
        m_valid && (first_cnt_reg == '0) && (second_cnt_reg == '0) && !ovf_reg)
        else $error("evaluate finish did not post result and clear lists");

endmodule

`default_nettype wire

@@ rtl/dmf_list_ram.sv @@
// ----------------------------------------------------------------------------
// dmf_list_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_list_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/dmf_fit_unit.sv @@
// ----------------------------------------------------------------------------
// dmf_fit_unit
// Four-stage product unit: operands, factor, fitness*factor, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_fit_unit
    import dmf_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic [15:0]   hom_scale,
    input  wire dmf_step_req_t req,
    output dmf_step_rsp_t      rsp
);

    localparam logic [33:0] ONE_HET = 34'd1 << 30;
    localparam logic [33:0] ONE_HOM = 34'd1 << 29;
    localparam logic [64:0] HALF_HET = 65'd1 << 29;
    localparam logic [64:0] HALF_HOM = 65'd1 << 28;

    // stage 0: operands
    logic               v0_reg;
    logic               hom0_reg;
    logic signed [15:0] sel0_reg;
    logic signed [16:0] mb0_reg;
    logic [31:0]        f0_reg;

    // stage 1: factor
    logic               v1_reg;
    logic               hom1_reg;
    logic [33:0]        factor1_reg;
    logic [31:0]        f1_reg;

    // stage 2: full product
    logic               v2_reg;
    logic               hom2_reg;
    logic               neg2_reg;
    logic [63:0]        prod2_reg;

    // stage 3: result
    logic               v3_reg;
    logic [31:0]        fit3_reg;
    logic               sat3_reg;

    logic signed [32:0] term;
    logic [33:0]        factor_next;
    logic [64:0]        rsum;
    logic               ovf;
    logic [31:0]        fit_next;
    logic               sat_next;

    always_comb begin
        term        = sel0_reg * mb0_reg;
        factor_next = {term[32], term} + (hom0_reg ? ONE_HOM : ONE_HET);
    end

    always_comb begin
        rsum = {1'b0, prod2_reg} + (hom2_reg ? HALF_HOM : HALF_HET);
        if (hom2_reg) begin
            ovf      = |rsum[64:61];
            fit_next = rsum[60:29];
        end else begin
            ovf      = |rsum[64:62];
            fit_next = rsum[61:30];
        end
        sat_next = 1'b0;
        if (neg2_reg) begin
            fit_next = '0;
            sat_next = 1'b1;
        end else if (ovf) begin
            fit_next = '1;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= req.go;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        hom0_reg    <= req.hom;
        sel0_reg    <= req.sel;
        mb0_reg     <= req.hom ? {1'b0, hom_scale} : {req.dom[15], req.dom};
        f0_reg      <= req.fitness;

        hom1_reg    <= hom0_reg;
        factor1_reg <= factor_next;
        f1_reg      <= f0_reg;

        hom2_reg    <= hom1_reg;
        neg2_reg    <= factor1_reg[33];
        prod2_reg   <= f1_reg * factor1_reg[31:0];

        fit3_reg    <= fit_next;
        sat3_reg    <= sat_next;
    end

    assign rsp = '{done: v3_reg, fitness: fit3_reg, sat: sat3_reg};

endmodule

`default_nettype wire
